FILE: sv/ccc_pkg.sv
// shared types and constants of the coin change combination counter
`default_nettype none

package ccc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_COIN_COUNT  = 3'd0;
  localparam logic [2:0] REG_COIN_FIRST  = 3'd1;
  localparam logic [2:0] REG_COIN_SECOND = 3'd2;
  localparam logic [2:0] REG_COIN_THIRD  = 3'd3;
  localparam logic [2:0] REG_COIN_FOURTH = 3'd4;

  // number of denomination registers
  localparam int COIN_SLOTS = 4;

  localparam int COUNT_W = 64;

  typedef logic [2:0]         cfg_index_t;
  typedef logic [9:0]         cfg_data_t;
  typedef logic [9:0]         amount_t;
  typedef logic [9:0]         coin_t;
  typedef logic [2:0]         coin_count_t;
  typedef logic [COUNT_W-1:0] count_t;

  // one table entry: count plus sticky overflow flag
  typedef struct packed {
    logic   sat;
    count_t value;
  } entry_t;

  localparam count_t COUNT_ONES = '1;

endpackage : ccc_pkg

`default_nettype wire

FILE: sv/coin_change_combination_count.sv
// coin change combination counter: table memory, update pipeline and control
`default_nettype none

// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+----------------------------------
// input    | in        | in_valid_i / in_stall_o    | target_amount_i
// output   | out       | out_valid_o / out_stall_i  | combination_count_o, saturated_o
// config   | in        | cfg_we_i (no wait)         | cfg_index_i, cfg_data_i
//
// in the run state one table update a cycle goes through the dual read port memory; a
// zero target or zero coin count finishes without any table work.
// reset clears control state and restores the default coins; the table needs no clearing,
// each transaction rewrites entries 0..T before it reads them.
// a result waiting under out_stall_i does not block the next input transaction.

module coin_change_combination_count #(
  parameter int MAX_AMOUNT = 1023,
  parameter int MAX_COINS  = 4
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // configuration write port
  input  wire                   cfg_we_i,
  input  wire ccc_pkg::cfg_index_t cfg_index_i,
  input  wire ccc_pkg::cfg_data_t  cfg_data_i,
  // input transactions
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire ccc_pkg::amount_t target_amount_i,
  // output transactions
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output ccc_pkg::count_t       combination_count_o,
  output logic                  saturated_o
);

  import ccc_pkg::*;

  localparam int DEPTH    = MAX_AMOUNT + 1;
  localparam int AW       = $clog2(DEPTH);
  localparam int USED_MAX = (MAX_COINS < COIN_SLOTS) ? MAX_COINS : COIN_SLOTS;

  // control states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // configuration registers
  coin_count_t coin_count_q;
  coin_t       coin_q [COIN_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coin_count_q <= coin_count_t'(4);
      coin_q[0]    <= coin_t'(25);
      coin_q[1]    <= coin_t'(10);
      coin_q[2]    <= coin_t'(5);
      coin_q[3]    <= coin_t'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COIN_COUNT:  coin_count_q <= cfg_data_i[2:0];
        REG_COIN_FIRST:  coin_q[0]    <= cfg_data_i;
        REG_COIN_SECOND: coin_q[1]    <= cfg_data_i;
        REG_COIN_THIRD:  coin_q[2]    <= cfg_data_i;
        REG_COIN_FOURTH: coin_q[3]    <= cfg_data_i;
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  // control registers
  logic [2:0]    state_q, state_d;
  logic [AW-1:0] tgt_q, tgt_d;       // clamped target
  coin_count_t   used_q, used_d;     // clamped number of coins
  logic [AW-1:0] amt_q, amt_d;       // amount being cleared or updated
  coin_count_t   k_q, k_d;           // current coin position
  logic          zero_q, zero_d;     // answer is zero without any table work

  // update pipeline: issue stage registers
  logic          pv_q;               // an update read was issued last cycle
  logic [AW-1:0] pa_q;               // its destination address
  logic          fwd_a_q, fwd_b_q;   // read hit the entry written at the same edge

  // last write, also the source of the final answer
  entry_t        wr_data_q;

  // output register
  logic          out_valid_q;
  count_t        count_q;
  logic          sat_q;

  // table memory, one write and two read ports, registered reads
  entry_t        ways_mem [DEPTH];
  entry_t        rd_a_q, rd_b_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;
  logic [AW-1:0] mem_ra_a, mem_ra_b;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ways_mem[mem_wa] <= mem_wd;
    end
    rd_a_q <= ways_mem[mem_ra_a];
    rd_b_q <= ways_mem[mem_ra_b];
  end

  // current coin and its skip test
  coin_t         coin_cur;
  logic [AW-1:0] coin_amt;
  logic          coin_skip;
  logic [AW-1:0] tgt_in;
  coin_count_t   used_in;
  logic          issue;
  logic          out_load;

  assign coin_cur  = coin_q[k_q[1:0]];
  assign coin_amt  = AW'(coin_cur);
  assign coin_skip = (coin_cur == '0) || (32'(coin_cur) > 32'(tgt_q));

  assign tgt_in  = (32'(target_amount_i) > 32'(MAX_AMOUNT)) ? AW'(MAX_AMOUNT)
                                                            : AW'(target_amount_i);
  assign used_in = (coin_count_q > coin_count_t'(USED_MAX)) ? coin_count_t'(USED_MAX)
                                                             : coin_count_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign issue      = (state_q == ST_RUN);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // saturating update of the entry issued last cycle, with forwarding of the
  // write that landed at the same edge as its reads
  entry_t                op_a, op_b, upd;
  logic [COUNT_W:0]      sum;

  always_comb begin
    op_a = fwd_a_q ? wr_data_q : rd_a_q;
    op_b = fwd_b_q ? wr_data_q : rd_b_q;
    sum  = {1'b0, op_a.value} + {1'b0, op_b.value};
    upd.sat   = sum[COUNT_W] | op_a.sat | op_b.sat;
    upd.value = upd.sat ? COUNT_ONES : sum[COUNT_W-1:0];
  end

  // write port: clearing pass or update stage, never both
  always_comb begin
    mem_we = 1'b0;
    mem_wa = amt_q;
    mem_wd = '0;
    if (state_q == ST_CLEAR) begin
      mem_we       = 1'b1;
      mem_wd.value = (amt_q == '0) ? count_t'(1) : '0;
    end else if (pv_q) begin
      mem_we = 1'b1;
      mem_wa = pa_q;
      mem_wd = upd;
    end
  end

  assign mem_ra_a = amt_q;
  assign mem_ra_b = amt_q - coin_amt;

  // sequencer
  always_comb begin
    state_d = state_q;
    tgt_d   = tgt_q;
    used_d  = used_q;
    amt_d   = amt_q;
    k_d     = k_q;
    zero_d  = zero_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          tgt_d  = tgt_in;
          used_d = used_in;
          amt_d  = '0;
          k_d    = '0;
          if (tgt_in == '0 || used_in == '0) begin
            zero_d  = 1'b1;
            state_d = ST_DONE;
          end else begin
            zero_d  = 1'b0;
            state_d = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        if (amt_q == tgt_q) begin
          state_d = ST_SETUP;
        end else begin
          amt_d = amt_q + 1'b1;
        end
      end
      ST_SETUP: begin
        if (k_q == used_q) begin
          state_d = ST_DONE;
        end else if (coin_skip) begin
          k_d = k_q + 1'b1;
        end else begin
          amt_d   = coin_amt;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (amt_q == tgt_q) begin
          k_d     = k_q + 1'b1;
          state_d = ST_SETUP;
        end else begin
          amt_d = amt_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tgt_q       <= '0;
      used_q      <= '0;
      amt_q       <= '0;
      k_q         <= '0;
      zero_q      <= 1'b0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tgt_q   <= tgt_d;
      used_q  <= used_d;
      amt_q   <= amt_d;
      k_q     <= k_d;
      zero_q  <= zero_d;
      pv_q    <= issue;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pa_q    <= amt_q;
    fwd_a_q <= mem_we && (mem_wa == mem_ra_a);
    fwd_b_q <= mem_we && (mem_wa == mem_ra_b);
    if (mem_we) begin
      wr_data_q <= mem_wd;
    end
    // the last entry written is always ways[target]
    if (out_load) begin
      count_q <= zero_q ? '0 : wr_data_q.value;
      sat_q   <= zero_q ? 1'b0 : wr_data_q.sat;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign combination_count_o = count_q;
  assign saturated_o         = sat_q;

endmodule : coin_change_combination_count

`default_nettype wire

FILE: tb/sv/ccc_result_checker.sv
// result checker of the coin change combination counter: watches the channels and predicts
`timescale 1ns / 100ps

module ccc_result_checker #(
  parameter int MAX_AMOUNT = 1023,
  parameter int MAX_COINS  = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  ccc_pkg::cfg_index_t  cfg_index_i,
  input  ccc_pkg::cfg_data_t   cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  ccc_pkg::amount_t     target_amount_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  ccc_pkg::count_t      combination_count_i,
  input  logic                 saturated_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import ccc_pkg::*;

  // shadow copy of the coin registers
  coin_count_t coin_count = 3'd4;
  coin_t       coin_val [COIN_SLOTS] = '{10'd25, 10'd10, 10'd5, 10'd1};

  entry_t expected_counts [$];

  // bottom-up table of ways per amount, with a sticky overflow flag per entry
  count_t ways     [0:MAX_AMOUNT];
  logic   ways_sat [0:MAX_AMOUNT];

  int failures = 0;

  function automatic entry_t count_combinations(input amount_t target_raw);
    int     target;
    int     used;
    int     c;
    int     a;
    int     k;
    count_t sum;
    entry_t res;
    target = int'(target_raw);
    if (target > MAX_AMOUNT) target = MAX_AMOUNT;
    used = int'(coin_count);
    if (used > MAX_COINS) used = MAX_COINS;
    if (used > COIN_SLOTS) used = COIN_SLOTS;
    res = '0;
    if (target == 0 || used == 0) return res;
    ways[0]     = count_t'(1);
    ways_sat[0] = 1'b0;
    for (a = 1; a <= target; a++) begin
      ways[a]     = '0;
      ways_sat[a] = 1'b0;
    end
    for (k = 0; k < used; k++) begin
      c = int'(coin_val[k]);
      // zero coins and coins above the target add nothing
      if (c != 0 && c <= target) begin
        for (a = c; a <= target; a++) begin
          sum = ways[a] + ways[a - c];
          if (sum < ways[a] || ways_sat[a] || ways_sat[a - c]) begin
            ways[a]     = COUNT_ONES;
            ways_sat[a] = 1'b1;
          end else begin
            ways[a] = sum;
          end
        end
      end
    end
    res.sat   = ways_sat[target];
    res.value = ways_sat[target] ? COUNT_ONES : ways[target];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t want;
    if (!rst_ni) begin
      coin_count  = 3'd4;
      coin_val[0] = 10'd25;
      coin_val[1] = 10'd10;
      coin_val[2] = 10'd5;
      coin_val[3] = 10'd1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_COIN_COUNT:  coin_count  = cfg_data_i[2:0];
          REG_COIN_FIRST:  coin_val[0] = cfg_data_i;
          REG_COIN_SECOND: coin_val[1] = cfg_data_i;
          REG_COIN_THIRD:  coin_val[2] = cfg_data_i;
          REG_COIN_FOURTH: coin_val[3] = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_counts.size() == 0) begin
          $error("unexpected result: combination_count %0d saturated %0b",
                 combination_count_i, saturated_i);
          failures++;
        end else begin
          want = expected_counts.pop_front();
          if (combination_count_i !== want.value) begin
            $error("combination_count: expected %0d, actual %0d",
                   want.value, combination_count_i);
            failures++;
          end
          if (saturated_i !== want.sat) begin
            $error("saturated: expected %0b, actual %0b", want.sat, saturated_i);
            failures++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_counts.push_back(count_combinations(target_amount_i));
      end
    end
    fail_count_o <= failures;
    pending_o    <= expected_counts.size();
  end

endmodule : ccc_result_checker

FILE: tb/sv/tb_top.sv
// top of the coin change combination counter testbench: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_top;
  import ccc_pkg::*;

  localparam int HOLD_CYCLES     = 1500;  // long output hold-off, fills the block
  localparam int RANDOM_PHASES   = 7;
  localparam int ITEMS_PER_PHASE = 17;
  localparam int DRAIN_CYCLES    = 64;    // quiet time after the last result
  // indexes past the register list, writes there must be ignored
  localparam cfg_index_t REG_SPARE_FIRST = REG_COIN_FOURTH + 3'd1;

  // clock, reset and block inputs, all known from time zero
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we        = 1'b0;
  cfg_index_t cfg_index     = '0;
  cfg_data_t  cfg_data      = '0;
  logic       in_valid      = 1'b0;
  amount_t    target_amount = '0;
  logic       out_stall     = 1'b0;

  // block outputs
  logic   in_stall;
  logic   out_valid;
  count_t combination_count;
  logic   saturated;

  // checker status
  int fail_count;
  int pending;

  // idling profile, in cycles of a hundred
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // each increment asks the result sink for one long hold-off
  int hold_requests = 0;

  int sent_items    = 0;
  int coin_settings = 0;

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  coin_change_combination_count i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .target_amount_i     (target_amount),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .combination_count_o (combination_count),
    .saturated_o         (saturated)
  );

  ccc_result_checker i_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .target_amount_i     (target_amount),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .combination_count_i (combination_count),
    .saturated_i         (saturated),
    .fail_count_o        (fail_count),
    .pending_o           (pending)
  );

  // result sink: random stall, or a long hold-off counted here when asked for
  initial begin : result_sink
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // one register write; the enable stays high so writes can go back to back
  task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
  endtask

  // full coin setting, optionally with writes to the spare indexes as well
  task automatic load_coins(input coin_count_t cnt, input coin_t c1, input coin_t c2,
                            input coin_t c3, input coin_t c4, input bit spare);
    int idx;
    write_reg(REG_COIN_COUNT, cfg_data_t'(cnt));
    write_reg(REG_COIN_FIRST, c1);
    write_reg(REG_COIN_SECOND, c2);
    write_reg(REG_COIN_THIRD, c3);
    write_reg(REG_COIN_FOURTH, c4);
    if (spare) begin
      for (idx = int'(REG_SPARE_FIRST); idx < 8; idx++) begin
        write_reg(cfg_index_t'(idx), cfg_data_t'($urandom_range(0, 1023)));
      end
    end
    cfg_we <= 1'b0;
    coin_settings++;
  endtask

  // offer one target amount, with random idle cycles ahead of it
  task automatic send_amount(input amount_t amt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    target_amount <= amt;
    do @(posedge clk_i); while (in_stall);
    sent_items++;
  endtask

  // block is idle once every transaction in flight has come back; the first
  // edge lets the count take in the transaction accepted just now
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // mostly small targets keep the run short; a few span the whole range
  function automatic amount_t pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return amount_t'($urandom_range(0, 1023));
    if (r < 10) return $urandom_range(0, 1) ? '1 : '0;
    return amount_t'($urandom_range(0, 150));
  endfunction

  function automatic coin_t pick_coin();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return coin_t'($urandom_range(1, 1023));
    return coin_t'($urandom_range(1, 40));
  endfunction

  function automatic coin_count_t pick_coin_count();
    if ($urandom_range(0, 99) < 15) return coin_count_t'($urandom_range(0, 7));
    return coin_count_t'($urandom_range(1, 4));
  endfunction

  initial begin : stimulus
    int phase;
    int n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 16;
    recv_idle_pct = 46;

    // reset coins 25, 10, 5, 1: zero target, full range, alternating bit patterns
    send_amount(10'd0);
    send_amount(10'd1);
    send_amount(10'd25);
    send_amount(10'd100);
    send_amount(10'd1023);
    send_amount(10'd682);
    send_amount(10'd341);
    wait_drained();

    // the same coin four times: every position counts on its own
    load_coins(3'd4, 10'd1, 10'd1, 10'd1, 10'd1, 1'b0);
    send_amount(10'd4);
    send_amount(10'd10);
    send_amount(10'd1023);
    wait_drained();

    // no coins in use
    load_coins(3'd0, 10'd1, 10'd2, 10'd3, 10'd4, 1'b0);
    send_amount(10'd50);
    send_amount(10'd0);
    wait_drained();

    // coin count of 7 is limited to four, spare index writes change nothing
    load_coins(3'd7, 10'd1023, 10'd512, 10'd3, 10'd7, 1'b1);
    send_amount(10'd1023);
    send_amount(10'd1022);
    send_amount(10'd30);
    wait_drained();

    // a zero coin is skipped
    load_coins(3'd2, 10'd0, 10'd3, 10'd1, 10'd1, 1'b0);
    send_amount(10'd9);
    send_amount(10'd10);
    wait_drained();

    // single coin at its top value, just under and at the target
    load_coins(3'd1, 10'd1023, 10'd1, 10'd1, 10'd1, 1'b0);
    send_amount(10'd1022);
    send_amount(10'd1023);
    wait_drained();

    // count of 5 still uses four denominations
    load_coins(3'd5, 10'd1, 10'd2, 10'd3, 10'd4, 1'b0);
    send_amount(10'd100);
    send_amount(10'd0);
    send_amount(10'd1023);
    wait_drained();

    // random coin settings, each with a batch of random targets
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 16;
        recv_idle_pct = 46;
      end else if (phase < 5) begin
        send_idle_pct = 46;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_coins(pick_coin_count(), pick_coin(), pick_coin(), pick_coin(), pick_coin(),
                 bit'($urandom_range(0, 1)));
      // output held off while inputs keep coming, so the input side backs up
      if (phase == 5) hold_requests++;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_amount(pick_target());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d target amounts sent under %0d coin settings plus the reset setting",
             sent_items, coin_settings);
    $display("corner cases first, then random idling both ways and one long output hold-off");
    if (pending != 0) begin
      $error("%0d results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("coin_change_combination_count: match");
    end else begin
      $display("coin_change_combination_count: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #100000000;
    $display("coin_change_combination_count: mismatch");
    $finish;
  end

endmodule : tb_top
